FILE: rtl/ckst_pkg.sv
// Shared types, widths and codes for the corner keypoint suppression table.
package ckst_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 12;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int RESP_W     = 16;
  localparam int SLOT_W     = 8;
  localparam int MINR_W     = 15;
  localparam int DIA_W      = 6;
  localparam int DIA2_W     = 2 * DIA_W;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [MINR_W-1:0] MIN_RESPONSE_RST = MINR_W'(100);
  localparam logic [DIA_W-1:0]  DIAMETER_RST     = DIA_W'(6);

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RESPONSE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER     = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic [2:0] ACT_BELOW    = 3'd0;
  localparam logic [2:0] ACT_APPEND   = 3'd1;
  localparam logic [2:0] ACT_REPLACE  = 3'd2;
  localparam logic [2:0] ACT_SUPPRESS = 3'd3;
  localparam logic [2:0] ACT_FULL     = 3'd4;
  localparam logic [2:0] ACT_READ     = 3'd5;

  typedef struct packed {
    logic                     cmd;
    logic [COORD_BITS-1:0]    pixel_x;
    logic [COORD_BITS-1:0]    pixel_y;
    logic signed [RESP_W-1:0] response;
    logic [SLOT_W-1:0]        read_slot;
  } in_t;

  typedef struct packed {
    logic [2:0]               action;
    logic [SLOT_W-1:0]        slot;
    logic [COORD_BITS-1:0]    entry_x;
    logic [COORD_BITS-1:0]    entry_y;
    logic signed [RESP_W-1:0] entry_response;
    logic                     entry_valid;
    logic [CNT_W-1:0]         point_count;
  } out_t;

  // One stored keypoint.
  typedef struct packed {
    logic [COORD_BITS-1:0]    x;
    logic [COORD_BITS-1:0]    y;
    logic signed [RESP_W-1:0] resp;
  } entry_t;

  // Outcome of a scan over the table.
  typedef struct packed {
    logic             overlap;
    logic             found;
    logic [IDX_W-1:0] found_idx;
  } scan_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

endpackage

FILE: rtl/corner_keypoint_suppression_table.sv
// Top level of the corner keypoint suppression table: control, config and the cell ring.
//
// Items enter on in_valid/in_ready with an in_t payload; one result leaves per
// item on out_valid/out_ready with an out_t payload. A pixel item whose response
// does not exceed min_response skips the ring and goes straight to the result stage.
// Every other item (candidate pixel or read) rotates the ring of MAX_POINTS
// cells once past a single compare unit: it is accepted, takes MAX_POINTS
// ring steps, drains the two-stage compare pipeline and then writes back
// and registers the result. The ring rotation sets the item time; one item
// is in work at a time.
// Configuration goes in through cfg_we/cfg_index/cfg_wdata with no wait and
// should be written only while the block is idle.
// Reset (rst_n low, synchronous) clears the point count, the state machine and
// the output valid flag and loads the default threshold and diameter; the cells
// hold no reset value and are never read before being written.
// While out_ready is low a finished result is held in the output register;
// the block can accept and scan the next item meanwhile and holds that one's
// write-back until the output register frees up.
module corner_keypoint_suppression_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ckst_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ckst_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ckst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ckst_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ckst_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [MINR_W-1:0]    min_resp_r;
  logic [DIA_W-1:0]     dia_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [CNT_W-1:0]     cnt_nxt;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [DIA2_W-1:0]    dia2_r;
  in_t                  item_r;
  logic                 above_r;
  entry_t               rd_entry_r;
  logic                 out_valid_r;
  out_t                 out_data_r;
  out_t                 res;

  logic                 accept;
  logic                 load;
  logic                 scanning;
  logic                 above;
  logic                 rd_valid;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  entry_t               wr_data;
  entry_t               head;
  entry_t               cell_q [MAX_POINTS];
  scan_t                scan;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign scanning  = (state_r == ST_SCAN);
  assign load      = (state_r == ST_FIN) && (!out_valid_r || out_ready);
  assign above     = in_data.response > $signed({1'b0, min_resp_r});
  assign head      = cell_q[0];

  // Ring of cells; cell 0 is the head seen by the compare unit.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    ckst_cell u_cell (
      .clk      (clk),
      .shift_en (scanning),
      .shift_in (cell_q[(i + 1) % MAX_POINTS]),
      .wr_en    (wr_en && (wr_idx == IDX_W'(i))),
      .wr_data  (wr_data),
      .entry    (cell_q[i])
    );
  end

  ckst_cmp u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (accept),
    .s0_valid  (scanning && (CNT_W'(idx_r) < cnt_r)),
    .s0_idx    (idx_r),
    .head      (head),
    .cand_x    (item_r.pixel_x),
    .cand_y    (item_r.pixel_y),
    .cand_resp (item_r.response),
    .dia2      (dia2_r),
    .result    (scan)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_resp_r <= MIN_RESPONSE_RST;
      dia_r      <= DIAMETER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_RESPONSE: min_resp_r <= cfg_wdata[MINR_W-1:0];
        CFG_DIAMETER:     dia_r      <= cfg_wdata[DIA_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (accept) begin
          state_nxt = (in_data.cmd == CMD_READ || above) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == IDX_W'(MAX_POINTS - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r  <= in_data;
      above_r <= above;
      dia2_r  <= DIA2_W'(dia_r) * DIA2_W'(dia_r);
    end
    // Grab the requested entry as it passes the head.
    if (scanning && item_r.cmd == CMD_READ &&
        CNT_W'(idx_r) == CNT_W'(item_r.read_slot)) begin
      rd_entry_r <= head;
    end
  end

  assign rd_valid = CNT_W'(item_r.read_slot) < cnt_r;

  always_comb begin
    res             = '0;
    wr_en           = 1'b0;
    wr_idx          = cnt_r[IDX_W-1:0];
    wr_data.x       = item_r.pixel_x;
    wr_data.y       = item_r.pixel_y;
    wr_data.resp    = item_r.response;
    cnt_nxt         = cnt_r;
    priority if (item_r.cmd == CMD_READ) begin
      res.action = ACT_READ;
      res.slot   = item_r.read_slot;
      if (rd_valid) begin
        res.entry_x        = rd_entry_r.x;
        res.entry_y        = rd_entry_r.y;
        res.entry_response = rd_entry_r.resp;
        res.entry_valid    = 1'b1;
      end
    end else if (!above_r) begin
      res.action = ACT_BELOW;
    end else if (scan.found) begin
      res.action = ACT_REPLACE;
      res.slot   = SLOT_W'(scan.found_idx);
      wr_en      = load;
      wr_idx     = scan.found_idx;
    end else if (scan.overlap) begin
      res.action = ACT_SUPPRESS;
    end else if (cnt_r == CNT_W'(MAX_POINTS)) begin
      res.action = ACT_FULL;
    end else begin
      res.action = ACT_APPEND;
      res.slot   = SLOT_W'(cnt_r);
      wr_en      = load;
      cnt_nxt    = cnt_r + CNT_W'(1);
    end
    res.point_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS))
    else $error("point count above table size");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != $past(cnt_r) |-> $past(load) && cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("point count changed outside an append");

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !scanning)
    else $error("cell write during ring rotation");
`endif

endmodule

FILE: rtl/ckst_cell.sv
// One table cell: holds a keypoint and passes it to its neighbor while the ring rotates.
module ckst_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  ckst_pkg::entry_t shift_in,
  input  logic            wr_en,
  input  ckst_pkg::entry_t wr_data,
  output ckst_pkg::entry_t entry
);
  import ckst_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (shift_en) begin
      entry_nxt = shift_in;
    end else if (wr_en) begin
      entry_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

FILE: rtl/ckst_cmp.sv
// Overlap compare unit: squares distances at the ring head and tracks the first weaker hit.
module ckst_cmp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clr,
  input  logic                             s0_valid,
  input  logic [ckst_pkg::IDX_W-1:0]       s0_idx,
  input  ckst_pkg::entry_t                 head,
  input  logic [ckst_pkg::COORD_BITS-1:0]  cand_x,
  input  logic [ckst_pkg::COORD_BITS-1:0]  cand_y,
  input  logic signed [ckst_pkg::RESP_W-1:0] cand_resp,
  input  logic [ckst_pkg::DIA2_W-1:0]      dia2,
  output ckst_pkg::scan_t                  result
);
  import ckst_pkg::*;

  logic [COORD_BITS-1:0]    adx;
  logic [COORD_BITS-1:0]    ady;
  logic                     s1_v_r;
  logic [IDX_W-1:0]         s1_idx_r;
  logic [SQ_W-1:0]          s1_sqx_r;
  logic [SQ_W-1:0]          s1_sqy_r;
  logic signed [RESP_W-1:0] s1_resp_r;
  logic [SQ_W:0]            dist2;
  logic                     hit;
  scan_t                    scan_r;
  scan_t                    scan_nxt;

  assign adx = (cand_x >= head.x) ? cand_x - head.x : head.x - cand_x;
  assign ady = (cand_y >= head.y) ? cand_y - head.y : head.y - cand_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= s0_idx;
    s1_sqx_r  <= SQ_W'(adx) * SQ_W'(adx);
    s1_sqy_r  <= SQ_W'(ady) * SQ_W'(ady);
    s1_resp_r <= head.resp;
  end

  assign dist2 = {1'b0, s1_sqx_r} + {1'b0, s1_sqy_r};
  assign hit   = dist2 < (SQ_W + 1)'(dia2);

  // Stop at the first overlapping entry that the candidate beats.
  always_comb begin
    scan_nxt = scan_r;
    if (clr) begin
      scan_nxt = '0;
    end else if (s1_v_r && !scan_r.found && hit) begin
      scan_nxt.overlap = 1'b1;
      if (cand_resp > s1_resp_r) begin
        scan_nxt.found     = 1'b1;
        scan_nxt.found_idx = s1_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  assign result = scan_r;

`ifndef SYNTHESIS
  a_found_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.found |-> scan_r.overlap)
    else $error("replacement found without overlap");

  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    scan_r.found && !clr |=> scan_r.found && $stable(scan_r.found_idx))
    else $error("first replacement slot changed during scan");

  a_clr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    clr |=> !scan_r.overlap && !scan_r.found)
    else $error("scan flags not cleared at item start");
`endif

endmodule
